[sv/c_string_literal_unescape_macros.svh]
// Assertion macros shared by the string literal decoder RTL.
// Each macro expands to one labeled concurrent assertion, sampled on clk_i
// and switched off while rst_ni is low.
`ifndef C_STRING_LITERAL_UNESCAPE_MACROS_SVH
`define C_STRING_LITERAL_UNESCAPE_MACROS_SVH

// Same-cycle implication
`define CSLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CSLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cslu_pkg.sv]
// ----------------------------------------------------------------------------
// cslu_pkg
// Types and character constants for the C string literal decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cslu_pkg;

  // Input item: one character of the literal
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       out_last;
  } out_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PH_WS     = 8'b0000_0001,
    PH_BODY   = 8'b0000_0010,
    PH_ESC    = 8'b0000_0100,
    PH_OCT    = 8'b0000_1000,
    PH_HEX0   = 8'b0001_0000,
    PH_HEX1   = 8'b0010_0000,
    PH_CLOSED = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_e;

  // Characters recognized by the parser
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_V  = 8'h76;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;

  // Decoded values of the named escapes
  localparam logic [7:0] ESC_BEL = 8'h07;
  localparam logic [7:0] ESC_BS  = 8'h08;
  localparam logic [7:0] ESC_HT  = 8'h09;
  localparam logic [7:0] ESC_LF  = 8'h0A;
  localparam logic [7:0] ESC_VT  = 8'h0B;
  localparam logic [7:0] ESC_FF  = 8'h0C;
  localparam logic [7:0] ESC_CR  = 8'h0D;

endpackage

[sv/c_string_literal_unescape.sv]
// The input stage registers each accepted item, and the result buffer registers its results.
// Throughput: one item per cycle while each item yields at most one result and
// the output is not stalled; an item that yields more results (up to 3) holds
// the input until its last result is being taken from the result buffer.
// Reset: rst_ni (async, active low) clears the input stage, result buffer and
// parser state to the leading whitespace phase.
// ----------------------------------------------------------------------------
// c_string_literal_unescape
// Streaming decoder for one double-quoted C string literal: skips leading
// whitespace, decodes octal, hex and named escapes, and closes each string
// with one status result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "c_string_literal_unescape_macros.svh"

module c_string_literal_unescape
  import cslu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Input stage
  logic s1_valid_q;
  in_t  s1_item_q;

  // Parser state
  phase_e     phase_q, phase_d;
  logic [7:0] esc_val_q, esc_val_d;
  logic [1:0] dig_cnt_q, dig_cnt_d;
  logic       three_ok_q, three_ok_d;
  logic       err_q, err_d;

  // Result buffer, slot 0 is the head
  out_t       res_q [3];
  out_t       res_d [3];
  logic [1:0] res_cnt_q;
  logic [1:0] res_n;

  logic take;
  logic pop;
  logic step;

  // Character classes of the staged character
  logic [7:0] ch;
  logic       is_oct;
  logic       is_hex;
  logic [3:0] hex_val;
  logic [7:0] oct_val;

  assign ch     = s1_item_q.in_char;
  assign is_oct = (ch >= CH_0) && (ch <= CH_7);
  assign oct_val = ch - CH_0;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if ((ch >= CH_0) && (ch <= CH_9)) begin
      hex_val = 4'(ch - CH_0);
    end else if ((ch >= CH_LC_A) && (ch <= CH_LC_F)) begin
      hex_val = 4'(ch - CH_LC_A + 8'd10);
    end else if ((ch >= CH_UC_A) && (ch <= CH_UC_F)) begin
      hex_val = 4'(ch - CH_UC_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Handshakes
  assign pop         = out_valid_o && out_ready_i;
  assign take        = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && out_ready_i);
  assign step        = s1_valid_q && take;
  assign in_ready_o  = !s1_valid_q || take;
  assign out_valid_o = (res_cnt_q != 2'd0);
  assign out_data_o  = res_q[0];

  // One character through the parser, up to three results
  always_comb begin
    logic       go;
    logic [1:0] limit;
    logic [1:0] dc_inc;
    logic [7:0] byte_v;

    phase_d    = phase_q;
    esc_val_d  = esc_val_q;
    dig_cnt_d  = dig_cnt_q;
    three_ok_d = three_ok_q;
    err_d      = err_q;
    res_n      = 2'd0;
    go         = 1'b1;
    limit      = three_ok_q ? 2'd3 : 2'd2;
    dc_inc     = dig_cnt_q + 2'd1;
    byte_v     = ch;
    for (int i = 0; i < 3; i++) begin
      res_d[i] = '{out_byte: 8'd0, out_kind: KIND_BYTE, out_last: 1'b0};
    end

    // Pending escapes: either absorb the digit or flush the escape byte
    if (phase_q == PH_OCT) begin
      if (is_oct && (dig_cnt_q < limit)) begin
        esc_val_d = {esc_val_q[4:0], oct_val[2:0]};
        dig_cnt_d = dc_inc;
        go        = 1'b0;
        if (dc_inc >= limit) begin
          res_d[res_n].out_byte = esc_val_d;
          res_n   = res_n + 2'd1;
          phase_d = PH_BODY;
        end
      end else begin
        res_d[res_n].out_byte = esc_val_q;
        res_n   = res_n + 2'd1;
        phase_d = PH_BODY;
      end
    end else if (phase_q == PH_HEX0) begin
      if (is_hex) begin
        esc_val_d = {4'd0, hex_val};
        phase_d   = PH_HEX1;
        go        = 1'b0;
      end else begin
        res_d[res_n].out_byte = esc_val_q;
        res_n   = res_n + 2'd1;
        phase_d = PH_BODY;
      end
    end else if (phase_q == PH_HEX1) begin
      phase_d = PH_BODY;
      if (is_hex) begin
        res_d[res_n].out_byte = {esc_val_q[3:0], hex_val};
        res_n = res_n + 2'd1;
        go    = 1'b0;
      end else begin
        res_d[res_n].out_byte = esc_val_q;
        res_n = res_n + 2'd1;
      end
    end

    // Main dispatch on the (possibly updated) phase
    if (go) begin
      unique case (phase_d)
        PH_WS: begin
          if ((ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR))) begin
            phase_d = PH_WS;
          end else if (ch == CH_QUOTE) begin
            phase_d = PH_BODY;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_BODY: begin
          if (ch == CH_NUL) begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end else if (ch == CH_QUOTE) begin
            phase_d = PH_CLOSED;
          end else if (ch == CH_BSL) begin
            phase_d = PH_ESC;
          end else begin
            res_d[res_n].out_byte = ch;
            res_n = res_n + 2'd1;
          end
        end
        PH_ESC: begin
          if (ch == CH_NUL) begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end else if (is_oct) begin
            esc_val_d  = oct_val;
            dig_cnt_d  = 2'd1;
            three_ok_d = (ch <= CH_3);
            phase_d    = PH_OCT;
          end else if ((ch == CH_LC_X) || (ch == CH_UC_X)) begin
            esc_val_d = ch;
            phase_d   = PH_HEX0;
          end else begin
            case (ch)
              CH_LC_A: byte_v = ESC_BEL;
              CH_LC_B: byte_v = ESC_BS;
              CH_LC_T: byte_v = ESC_HT;
              CH_LC_N: byte_v = ESC_LF;
              CH_LC_V: byte_v = ESC_VT;
              CH_LC_F: byte_v = ESC_FF;
              CH_LC_R: byte_v = ESC_CR;
              default: byte_v = ch;
            endcase
            res_d[res_n].out_byte = byte_v;
            res_n   = res_n + 2'd1;
            phase_d = PH_BODY;
          end
        end
        PH_CLOSED: begin
          if (ch != CH_NUL) begin
            err_d = 1'b1;
          end
          phase_d = PH_DONE;
        end
        PH_OCT, PH_HEX0, PH_HEX1, PH_DONE: begin
          phase_d = phase_d;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end

    // End of string: flush a pending escape, then the status result
    if (s1_item_q.in_last) begin
      if ((phase_d == PH_OCT) || (phase_d == PH_HEX0) || (phase_d == PH_HEX1)) begin
        res_d[res_n].out_byte = esc_val_d;
        res_n = res_n + 2'd1;
        err_d = 1'b1;
      end else if ((phase_d != PH_CLOSED) && (phase_d != PH_DONE)) begin
        err_d = 1'b1;
      end
      res_d[res_n].out_kind = err_d ? KIND_BAD : KIND_OK;
      res_d[res_n].out_last = 1'b1;
      res_n      = res_n + 2'd1;
      phase_d    = PH_WS;
      esc_val_d  = 8'd0;
      dig_cnt_d  = 2'd0;
      three_ok_d = 1'b0;
      err_d      = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      res_cnt_q  <= 2'd0;
      phase_q    <= PH_WS;
      esc_val_q  <= 8'd0;
      dig_cnt_q  <= 2'd0;
      three_ok_q <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (take) begin
        s1_valid_q <= 1'b0;
      end

      if (step) begin
        res_cnt_q  <= res_n;
        phase_q    <= phase_d;
        esc_val_q  <= esc_val_d;
        dig_cnt_q  <= dig_cnt_d;
        three_ok_q <= three_ok_d;
        err_q      <= err_d;
      end else if (pop) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (step) begin
      res_q <= res_d;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  // Checks
  `CSLU_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_q), "parser phase not one-hot")
  `CSLU_ASSERT_NOW(a_err_done, err_q, phase_q == PH_DONE, "error latched outside done phase")
  `CSLU_ASSERT_NOW(a_no_overrun, s1_valid_q && !take, !in_ready_o,
                   "input stage would be overwritten")
  `CSLU_ASSERT_NEXT(a_last_resets, step && s1_item_q.in_last, phase_q == PH_WS && !err_q,
                    "parser not reset after last item")
  `CSLU_ASSERT_NOW(a_last_kind, out_valid_o,
                   out_data_o.out_last == (out_data_o.out_kind != KIND_BYTE),
                   "status result and last flag disagree")

endmodule

[tb/c_string_literal_unescape_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_string_literal_unescape_tb
// Feeds quoted C string literals one character per item, predicts the decoded
// bytes and the status item of each string, and checks every result item in
// order. A short directed set covers the escape corner cases; random strings
// follow, mostly well-formed with some broken ones and raw noise.
// ----------------------------------------------------------------------------

module c_string_literal_unescape_tb;
  import cslu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CHARS   = 215;
  localparam int IDLE_PCT       = 24;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  c_string_literal_unescape i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Characters waiting to be sent, and decoded items waiting to come out
  in_t        char_q[$];
  out_t       decoded_q[$];
  logic [7:0] str_q[$];
  int         chars_sent   = 0;
  int         random_chars = 0;
  int         mismatch_cnt = 0;
  int         quiet_cycles = 0;

  // Decoder state mirror
  phase_e     parse_ph;
  logic [7:0] esc_val;
  logic [1:0] digit_cnt;
  logic       three_ok;
  logic       malformed;
  int         step_results;

  // No idling on either side for a stretch in the middle of the random part
  wire calm = (chars_sent >= 110) && (chars_sent < 170);

  function automatic void clear_decoder();
    parse_ph  = PH_WS;
    esc_val   = '0;
    digit_cnt = '0;
    three_ok  = 1'b0;
    malformed = 1'b0;
  endfunction

  function automatic void push_result(logic [7:0] b, kind_e kind, logic last);
    out_t r;
    if (step_results >= 3) return;
    r.out_byte = b;
    r.out_kind = kind;
    r.out_last = last;
    decoded_q.push_back(r);
    step_results++;
  endfunction

  function automatic void mark_malformed();
    malformed = 1'b1;
    parse_ph  = PH_DONE;
  endfunction

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
    return -1;
  endfunction

  // Expected result items for one accepted character
  function automatic void decode_char(in_t item);
    logic [7:0] c;
    logic       is_oct;
    int         hv;
    logic [1:0] lim;
    logic       taken;
    c      = item.in_char;
    is_oct = (c >= CH_0) && (c <= CH_7);
    hv     = hex_digit_value(c);
    taken  = 1'b0;
    step_results = 0;

    // Pending escape: extend it, or flush it and handle c in the body
    case (parse_ph)
      PH_OCT: begin
        lim = three_ok ? 2'd3 : 2'd2;
        if (is_oct && digit_cnt < lim) begin
          esc_val   = {esc_val[4:0], c[2:0]};
          digit_cnt = digit_cnt + 2'd1;
          if (digit_cnt >= lim) begin
            push_result(esc_val, KIND_BYTE, 1'b0);
            parse_ph = PH_BODY;
          end
          taken = 1'b1;
        end else begin
          push_result(esc_val, KIND_BYTE, 1'b0);
          parse_ph = PH_BODY;
        end
      end
      PH_HEX0: begin
        if (hv >= 0) begin
          esc_val  = hv[7:0];
          parse_ph = PH_HEX1;
          taken    = 1'b1;
        end else begin
          push_result(esc_val, KIND_BYTE, 1'b0);
          parse_ph = PH_BODY;
        end
      end
      PH_HEX1: begin
        if (hv >= 0) begin
          push_result({esc_val[3:0], hv[3:0]}, KIND_BYTE, 1'b0);
          parse_ph = PH_BODY;
          taken    = 1'b1;
        end else begin
          push_result(esc_val, KIND_BYTE, 1'b0);
          parse_ph = PH_BODY;
        end
      end
      default: ;
    endcase

    if (!taken) begin
      case (parse_ph)
        PH_WS: begin
          if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            if (c == CH_QUOTE) parse_ph = PH_BODY;
            else mark_malformed();
          end
        end
        PH_BODY: begin
          if (c == CH_NUL) mark_malformed();
          else if (c == CH_QUOTE) parse_ph = PH_CLOSED;
          else if (c == CH_BSL) parse_ph = PH_ESC;
          else push_result(c, KIND_BYTE, 1'b0);
        end
        PH_ESC: begin
          if (c == CH_NUL) begin
            mark_malformed();
          end else if (is_oct) begin
            esc_val   = {5'd0, c[2:0]};
            digit_cnt = 2'd1;
            three_ok  = (c <= CH_3);
            parse_ph  = PH_OCT;
          end else if (c == CH_LC_X || c == CH_UC_X) begin
            esc_val  = c;
            parse_ph = PH_HEX0;
          end else begin
            case (c)
              CH_LC_A: c = ESC_BEL;
              CH_LC_B: c = ESC_BS;
              CH_LC_T: c = ESC_HT;
              CH_LC_N: c = ESC_LF;
              CH_LC_V: c = ESC_VT;
              CH_LC_F: c = ESC_FF;
              CH_LC_R: c = ESC_CR;
              default: ;
            endcase
            push_result(c, KIND_BYTE, 1'b0);
            parse_ph = PH_BODY;
          end
        end
        PH_CLOSED: begin
          if (c == CH_NUL) parse_ph = PH_DONE;
          else mark_malformed();
        end
        default: ;
      endcase
    end

    // Last character: flush a pending escape, then the status item
    if (item.in_last) begin
      if (parse_ph == PH_OCT || parse_ph == PH_HEX0 || parse_ph == PH_HEX1) begin
        push_result(esc_val, KIND_BYTE, 1'b0);
        mark_malformed();
      end else if (parse_ph != PH_CLOSED && parse_ph != PH_DONE) begin
        mark_malformed();
      end
      push_result(8'h00, malformed ? KIND_BAD : KIND_OK, 1'b1);
      clear_decoder();
    end
  endfunction

  // String building
  function automatic void put(logic [7:0] c);
    str_q.push_back(c);
  endfunction

  function automatic void close_string();
    in_t item;
    foreach (str_q[i]) begin
      item.in_char = str_q[i];
      item.in_last = (i == str_q.size() - 1);
      char_q.push_back(item);
    end
    random_chars += str_q.size();
    str_q.delete();
  endfunction

  function automatic logic [7:0] ws_char();
    int v;
    v = $urandom_range(9, 14);
    return (v == 14) ? CH_SPACE : v[7:0];
  endfunction

  function automatic logic [7:0] hex_char();
    string hex_set;
    hex_set = "0123456789abcdefABCDEF";
    return hex_set[$urandom_range(0, 21)];
  endfunction

  // One plain character or one escape sequence inside the quotes
  function automatic void add_body_piece();
    string      named_set;
    logic [7:0] c;
    named_set = "abtnvfr";
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        c = 8'($urandom_range(1, 255));
        if (c == CH_QUOTE || c == CH_BSL) c = CH_LC_A;
        put(c);
      end
      3: begin
        put(CH_BSL);
        put(named_set[$urandom_range(0, 6)]);
      end
      4, 5: begin
        put(CH_BSL);
        put(8'(CH_0 + $urandom_range(0, 7)));
        repeat ($urandom_range(0, 3)) put(8'(CH_0 + $urandom_range(0, 9)));
      end
      6, 7: begin
        put(CH_BSL);
        put($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) != 0) put(hex_char());
          else put(8'($urandom_range(32, 126)));
        end
      end
      8: begin
        put(CH_BSL);
        put(8'($urandom_range(1, 255)));
      end
      default: begin
        c = 8'($urandom_range(32, 126));
        if (c == CH_QUOTE) c = CH_UC_X;
        put(c);
      end
    endcase
  endfunction

  function automatic void gen_string();
    int shape;
    shape = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) put(ws_char());
    if (shape < 80) begin
      // well-formed, sometimes with a NUL and ignored tail after the quote
      put(CH_QUOTE);
      repeat ($urandom_range(0, 6)) add_body_piece();
      put(CH_QUOTE);
      if ($urandom_range(0, 9) == 0) begin
        put(CH_NUL);
        repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
      end
    end else if (shape < 90) begin
      // broken: no opening quote, cut short, or junk after the closing quote
      if ($urandom_range(0, 3) != 0) put(CH_QUOTE);
      repeat ($urandom_range(0, 4)) add_body_piece();
      case ($urandom_range(0, 2))
        0: put(CH_BSL);
        1: ;
        default: begin
          put(CH_QUOTE);
          put(8'($urandom_range(1, 255)));
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
    end
    if (str_q.size() == 0) put(8'($urandom_range(0, 255)));
    close_string();
  endfunction

  // Sender: predicts on acceptance, then offers the next character or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(in_data);
        chars_sent++;
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and in-order compare
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          if (mismatch_cnt < 10) $display("unexpected result item %h", out_data);
          mismatch_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.out_kind !== want.out_kind ||
              out_data.out_last !== want.out_last) begin
            if (mismatch_cnt < 10) begin
              $display("mismatch: byte %h exp %h, kind %0d exp %0d, last %0b exp %0b",
                       out_data.out_byte, want.out_byte, out_data.out_kind, want.out_kind,
                       out_data.out_last, want.out_last);
            end
            mismatch_cnt++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (char_q.size() != 0 || in_valid || decoded_q.size() != 0);
  endtask

  initial begin
    clear_decoder();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3-digit octal, 2-digit octal limit, \x with no hex digit
    put(CH_SPACE); put(CH_QUOTE);
    put(CH_BSL); put(CH_3); put(CH_7); put(CH_7);
    put(CH_BSL); put(8'(CH_0 + 8'd4)); put(CH_7); put(CH_7);
    put(CH_BSL); put(CH_LC_X); put("g"); put(CH_QUOTE);
    close_string();
    // no opening quote
    put(CH_LC_A);
    close_string();
    // two-digit hex, other escape, byte 0xff, NUL after closing quote
    put(CH_QUOTE); put(CH_BSL); put(CH_UC_X); put(CH_LC_F); put(CH_UC_F);
    put(CH_BSL); put("q"); put(8'hFF); put(CH_QUOTE); put(CH_NUL);
    close_string();
    // trailing backslash
    put(CH_QUOTE); put(CH_BSL);
    close_string();
    // NUL inside the body, then more text
    put(CH_QUOTE); put(CH_NUL); put("z");
    close_string();
    // octal escape still open at the last character
    put(CH_QUOTE); put(CH_BSL); put(8'(CH_0 + 8'd1));
    close_string();

    // hold off until every directed result is back
    wait_drained();

    random_chars = 0;
    while (random_chars < RANDOM_CHARS) gen_string();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/cslu_pkg.sv
sv/c_string_literal_unescape.sv
tb/c_string_literal_unescape_tb.sv
